>>> hdl/assert_macros.svh
// Assertion macros for the checker file.
// Needs nothing else; files that use these take it in by include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a given clock with an active-low reset.
`define QCR_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the usual clk_i / rst_ni pair of the enclosing module.
`define QCR_ASSERT(lbl, prop, msg) \
  `QCR_ASSERT_RST(lbl, clk_i, rst_ni, prop, msg)

`endif

>>> hdl/qcr_pkg.sv
// Types, constants and helpers of the quaternion compose/renormalize block.
// No dependencies; used by the channel interfaces, the top level and the checker.
package qcr_pkg;

  localparam int PART_W     = 32;   // Q3.28 part width
  localparam int FRAC_W     = 28;
  localparam int PROD_W     = 2 * PART_W;
  localparam int ACC_W      = PROD_W + 2;  // four products, exact
  localparam int PERIOD_W   = 7;
  localparam int CFG_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam int STEP_W     = 5;
  localparam logic [STEP_W-1:0] LAST_COMPOSE = 5'd15;
  localparam logic [STEP_W-1:0] LAST_SQUARE  = 5'd19;

  // square root: 66-bit radicand, two bits per step
  localparam int ROOT_W     = 33;
  localparam int SQRT_ITERS = ACC_W / 2;
  localparam int REM_W      = ROOT_W + 1;
  // divide: quotient never exceeds 2^28
  localparam int QUOT_W     = FRAC_W + 1;
  localparam int DIV_ITERS  = QUOT_W;
  localparam int NUM_W      = PART_W + FRAC_W;
  localparam int UNIT_W     = REM_W + 2;
  localparam int ITER_W     = 6;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 7'd97;
  localparam logic [CFG_ADDR_W-3:0] REG_RENORM_PERIOD = '0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SQRT,
    ST_DIV_LOAD,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic signed [PART_W-1:0] x;
    logic signed [PART_W-1:0] y;
    logic signed [PART_W-1:0] z;
    logic signed [PART_W-1:0] w;
  } quat_t;

  // products that enter their part's sum with a minus sign
  function automatic logic prod_neg(input logic [STEP_W-1:0] idx);
    logic neg;
    case (idx)
      5'd3, 5'd7, 5'd11, 5'd13, 5'd14, 5'd15: neg = 1'b1;
      default: neg = 1'b0;
    endcase
    return neg;
  endfunction

endpackage

>>> hdl/qcr_in_if.sv
// Input channel: valid/ready plus the two quaternions of one beat.
// Depends on qcr_pkg.
interface qcr_in_if;
  import qcr_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [PART_W-1:0] first_x;
  logic signed [PART_W-1:0] first_y;
  logic signed [PART_W-1:0] first_z;
  logic signed [PART_W-1:0] first_w;
  logic signed [PART_W-1:0] second_x;
  logic signed [PART_W-1:0] second_y;
  logic signed [PART_W-1:0] second_z;
  logic signed [PART_W-1:0] second_w;

  modport source (
    output valid, first_x, first_y, first_z, first_w,
           second_x, second_y, second_z, second_w,
    input  ready
  );
  modport sink (
    input  valid, first_x, first_y, first_z, first_w,
           second_x, second_y, second_z, second_w,
    output ready
  );
endinterface

>>> hdl/qcr_out_if.sv
// Output channel: valid/ready plus the composed quaternion and its flag.
// Depends on qcr_pkg.
interface qcr_out_if;
  import qcr_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [PART_W-1:0] out_x;
  logic signed [PART_W-1:0] out_y;
  logic signed [PART_W-1:0] out_z;
  logic signed [PART_W-1:0] out_w;
  logic                     renormalized;

  modport source (
    output valid, out_x, out_y, out_z, out_w, renormalized,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, out_z, out_w, renormalized,
    output ready
  );
endinterface

>>> hdl/quaternion_compose_renormalize.sv
// Quaternion composition with periodic renormalization, Q3.28 fixed point.
// Depends on qcr_pkg, qcr_in_if and qcr_out_if.
//
//  channel   dir  handshake              payload
//  in_ch_i   in   valid/ready            first_{x,y,z,w}, second_{x,y,z,w}
//  out_ch_o  out  valid/ready            out_{x,y,z,w}, renormalized
//  apb       in   psel/penable/pwrite    paddr[2:0], pwdata; prdata, pready=1
//
// Without renormalization a beat is paced by its 16 products, one per cycle
//   through the single 32x32 multiplier.
// A renormalizing beat adds 4 squares on the multiplier, then 33 root steps
//   and 4 x 29 divide steps on the one shared 36-bit subtract/compare unit.
// The result sits in an output register; a new beat is taken while it waits.
//   A finished result that finds the register still full holds the sequencer.
// Reset is asynchronous, active low; renorm_period comes up at 97, count at 0.
module quaternion_compose_renormalize (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  qcr_in_if.sink                            in_ch_i,
  qcr_out_if.source                         out_ch_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [qcr_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [qcr_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [qcr_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import qcr_pkg::*;

  // rounding half and saturation bounds in accumulator width
  localparam logic signed [ACC_W-1:0] RND_HALF =
    {{(ACC_W-FRAC_W){1'b0}}, 1'b1, {(FRAC_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] SAT_MAX =
    {{(ACC_W-PART_W+1){1'b0}}, {(PART_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_MIN =
    {{(ACC_W-PART_W+1){1'b1}}, {(PART_W-1){1'b0}}};

  // ---------------- control state
  state_e                state_q, state_d;
  logic [PERIOD_W-1:0]   period_q;
  logic [PERIOD_W-1:0]   count_q;
  logic                  fire_q;     // this beat renormalizes
  logic [STEP_W-1:0]     step_q;     // next product to issue
  logic [STEP_W-1:0]     iss_q;      // product now in prod_q
  logic                  pend_q;     // prod_q holds a live product
  logic [ITER_W-1:0]     iter_q;
  logic [1:0]            pidx_q;     // part under division
  logic                  out_valid_q;

  // ---------------- datapath
  quat_t                      first_q, second_q, res_q, out_q;
  logic                       out_renorm_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [ACC_W-1:0]    acc_q;
  logic [ACC_W-1:0]           sq_sh_q;    // radicand, consumed two bits a step
  logic [REM_W-1:0]           rt_rem_q;
  logic [ROOT_W-1:0]          root_q;     // magnitude m once the root is done
  logic [ROOT_W-1:0]          dv_rem_q;
  logic [QUOT_W-1:0]          low_q;      // numerator bits still to bring down
  logic [QUOT_W-1:0]          quot_q;
  logic                       neg_q;

  // ---------------- handshakes and config
  logic in_acc, out_acc, cfg_wr, out_load;
  logic [PERIOD_W:0] count_inc;
  logic fire_now;

  assign in_ch_i.ready = (state_q == ST_IDLE);
  assign in_acc        = in_ch_i.valid && in_ch_i.ready;
  assign out_acc       = out_valid_q && out_ch_o.ready;
  assign out_load      = (state_q == ST_DONE) && (!out_valid_q || out_ch_o.ready);

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[CFG_ADDR_W-1:2] == REG_RENORM_PERIOD);
  assign prdata = (paddr[CFG_ADDR_W-1:2] == REG_RENORM_PERIOD) ?
                  {{(APB_DATA_W-PERIOD_W){1'b0}}, period_q} : '0;

  // a period of zero, or any period at or below the count, fires at once
  assign count_inc = {1'b0, count_q} + {{PERIOD_W{1'b0}}, 1'b1};
  assign fire_now  = count_inc > {1'b0, period_q};

  // ---------------- multiplier: one product per cycle
  logic [STEP_W-1:0]        last_idx;
  logic                     issue;
  logic signed [PART_W-1:0] op_a, op_b;
  logic signed [PROD_W-1:0] prod_d;

  assign last_idx = fire_q ? LAST_SQUARE : LAST_COMPOSE;
  assign issue    = (state_q == ST_MUL) && (step_q <= last_idx);

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (step_q)
      5'd0:  begin op_a = first_q.x;  op_b = second_q.w; end
      5'd1:  begin op_a = second_q.x; op_b = first_q.w;  end
      5'd2:  begin op_a = second_q.y; op_b = first_q.z;  end
      5'd3:  begin op_a = second_q.z; op_b = first_q.y;  end
      5'd4:  begin op_a = first_q.y;  op_b = second_q.w; end
      5'd5:  begin op_a = second_q.y; op_b = first_q.w;  end
      5'd6:  begin op_a = second_q.z; op_b = first_q.x;  end
      5'd7:  begin op_a = second_q.x; op_b = first_q.z;  end
      5'd8:  begin op_a = first_q.z;  op_b = second_q.w; end
      5'd9:  begin op_a = second_q.z; op_b = first_q.w;  end
      5'd10: begin op_a = second_q.x; op_b = first_q.y;  end
      5'd11: begin op_a = second_q.y; op_b = first_q.x;  end
      5'd12: begin op_a = first_q.w;  op_b = second_q.w; end
      5'd13: begin op_a = first_q.x;  op_b = second_q.x; end
      5'd14: begin op_a = first_q.y;  op_b = second_q.y; end
      5'd15: begin op_a = first_q.z;  op_b = second_q.z; end
      // squares of the saturated parts for the magnitude
      5'd16: begin op_a = res_q.x;    op_b = res_q.x;    end
      5'd17: begin op_a = res_q.y;    op_b = res_q.y;    end
      5'd18: begin op_a = res_q.z;    op_b = res_q.z;    end
      5'd19: begin op_a = res_q.w;    op_b = res_q.w;    end
      default: begin op_a = '0;       op_b = '0;         end
    endcase
  end

  assign prod_d = op_a * op_b;

  // ---------------- accumulator: exact sum, parts preload the rounding half
  logic signed [ACC_W-1:0] prod_ext, acc_base, acc_sum, rnd_sh;
  logic signed [PART_W-1:0] sat_part;
  logic mul_done;

  assign prod_ext = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};

  always_comb begin
    if (iss_q[1:0] == 2'd0) begin
      acc_base = iss_q[STEP_W-1] ? '0 : RND_HALF;
    end else begin
      acc_base = acc_q;
    end
    acc_sum = prod_neg(iss_q) ? (acc_base - prod_ext) : (acc_base + prod_ext);
    rnd_sh  = acc_sum >>> FRAC_W;
    if (rnd_sh > SAT_MAX) begin
      sat_part = SAT_MAX[PART_W-1:0];
    end else if (rnd_sh < SAT_MIN) begin
      sat_part = SAT_MIN[PART_W-1:0];
    end else begin
      sat_part = rnd_sh[PART_W-1:0];
    end
  end

  assign mul_done = pend_q && (iss_q == last_idx);

  // ---------------- shared subtract/compare unit (root and divide)
  logic [UNIT_W-1:0] ua, ub;
  logic [UNIT_W:0]   udiff;
  logic              uge;

  always_comb begin
    case (state_q)
      ST_SQRT: begin
        ua = {rt_rem_q, sq_sh_q[ACC_W-1 -: 2]};
        ub = {1'b0, root_q, 2'b01};
      end
      ST_DIV: begin
        ua = {2'b00, dv_rem_q, low_q[QUOT_W-1]};
        ub = {3'b000, root_q};
      end
      default: begin
        ua = '0;
        ub = '0;
      end
    endcase
  end

  assign udiff = {1'b0, ua} - {1'b0, ub};
  assign uge   = !udiff[UNIT_W];

  // ---------------- divide setup and finish
  logic signed [PART_W-1:0] div_c;
  logic [PART_W-1:0]        div_mag;
  logic [NUM_W-1:0]         div_num;
  logic [QUOT_W-1:0]        quot_d;
  logic [PART_W-1:0]        quot_ext;
  logic signed [PART_W-1:0] div_part;
  logic                     sqrt_last, div_last;

  always_comb begin
    case (pidx_q)
      2'd0:    div_c = res_q.x;
      2'd1:    div_c = res_q.y;
      2'd2:    div_c = res_q.z;
      default: div_c = res_q.w;
    endcase
  end

  // |c| * 2^28 + m/2; the quotient of this by m is at most 2^28
  assign div_mag  = div_c[PART_W-1] ? PART_W'(-div_c) : div_c;
  assign div_num  = {div_mag, {FRAC_W{1'b0}}} +
                    {{(NUM_W-ROOT_W+1){1'b0}}, root_q[ROOT_W-1:1]};
  assign quot_d   = {quot_q[QUOT_W-2:0], uge};
  assign quot_ext = {{(PART_W-QUOT_W){1'b0}}, quot_d};
  assign div_part = neg_q ? -$signed(quot_ext) : $signed(quot_ext);

  assign sqrt_last = (iter_q == ITER_W'(SQRT_ITERS - 1));
  assign div_last  = (iter_q == ITER_W'(DIV_ITERS - 1));

  // ---------------- sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (in_acc) state_d = ST_MUL;
      ST_MUL:      if (mul_done) state_d = fire_q ? ST_SQRT : ST_DONE;
      ST_SQRT:     if (sqrt_last) state_d = ST_DIV_LOAD;
      // zero magnitude leaves the parts as they are
      ST_DIV_LOAD: state_d = (root_q == '0) ? ST_DONE : ST_DIV;
      ST_DIV:      if (div_last) state_d = (pidx_q == 2'd3) ? ST_DONE : ST_DIV_LOAD;
      ST_DONE:     if (out_load) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      period_q    <= PERIOD_RESET;
      count_q     <= '0;
      fire_q      <= 1'b0;
      step_q      <= '0;
      iss_q       <= '0;
      pend_q      <= 1'b0;
      iter_q      <= '0;
      pidx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_wr) period_q <= pwdata[PERIOD_W-1:0];
      if (in_acc) begin
        count_q <= fire_now ? '0 : count_inc[PERIOD_W-1:0];
        fire_q  <= fire_now;
        step_q  <= '0;
        pidx_q  <= '0;
      end else if (issue) begin
        step_q <= step_q + 1'b1;
      end
      pend_q <= issue;
      iss_q  <= step_q;
      case (state_q)
        ST_MUL:      iter_q <= '0;
        ST_SQRT:     iter_q <= sqrt_last ? '0 : iter_q + 1'b1;
        ST_DIV_LOAD: iter_q <= '0;
        ST_DIV: begin
          iter_q <= iter_q + 1'b1;
          if (div_last) pidx_q <= pidx_q + 1'b1;
        end
        default: iter_q <= '0;
      endcase
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------- datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      first_q  <= '{x: in_ch_i.first_x,  y: in_ch_i.first_y,
                    z: in_ch_i.first_z,  w: in_ch_i.first_w};
      second_q <= '{x: in_ch_i.second_x, y: in_ch_i.second_y,
                    z: in_ch_i.second_z, w: in_ch_i.second_w};
    end
    prod_q <= prod_d;
    if (pend_q) begin
      acc_q <= acc_sum;
      if (!iss_q[STEP_W-1] && (iss_q[1:0] == 2'd3)) begin
        case (iss_q[3:2])
          2'd0:    res_q.x <= sat_part;
          2'd1:    res_q.y <= sat_part;
          2'd2:    res_q.z <= sat_part;
          default: res_q.w <= sat_part;
        endcase
      end
    end
    case (state_q)
      ST_MUL: begin
        // sum of squares is complete: seed the root
        sq_sh_q  <= acc_sum;
        rt_rem_q <= '0;
        root_q   <= '0;
      end
      ST_SQRT: begin
        rt_rem_q <= uge ? udiff[REM_W-1:0] : ua[REM_W-1:0];
        root_q   <= {root_q[ROOT_W-2:0], uge};
        sq_sh_q  <= {sq_sh_q[ACC_W-3:0], 2'b00};
      end
      ST_DIV_LOAD: begin
        dv_rem_q <= {{(ROOT_W-(NUM_W-QUOT_W)){1'b0}}, div_num[NUM_W-1:QUOT_W]};
        low_q    <= div_num[QUOT_W-1:0];
        quot_q   <= '0;
        neg_q    <= div_c[PART_W-1];
      end
      ST_DIV: begin
        dv_rem_q <= uge ? udiff[ROOT_W-1:0] : ua[ROOT_W-1:0];
        low_q    <= {low_q[QUOT_W-2:0], 1'b0};
        quot_q   <= quot_d;
        if (div_last) begin
          case (pidx_q)
            2'd0:    res_q.x <= div_part;
            2'd1:    res_q.y <= div_part;
            2'd2:    res_q.z <= div_part;
            default: res_q.w <= div_part;
          endcase
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_q        <= res_q;
      out_renorm_q <= fire_q;
    end
  end

  assign out_ch_o.valid        = out_valid_q;
  assign out_ch_o.out_x        = out_q.x;
  assign out_ch_o.out_y        = out_q.y;
  assign out_ch_o.out_z        = out_q.z;
  assign out_ch_o.out_w        = out_q.w;
  assign out_ch_o.renormalized = out_renorm_q;

endmodule

>>> hdl/qcr_checker.sv
// Port-level checker for quaternion_compose_renormalize, bound to the top level.
// Depends on qcr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module qcr_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic signed [qcr_pkg::PART_W-1:0] out_x_i,
  input logic signed [qcr_pkg::PART_W-1:0] out_y_i,
  input logic signed [qcr_pkg::PART_W-1:0] out_z_i,
  input logic signed [qcr_pkg::PART_W-1:0] out_w_i,
  input logic                              renorm_i
);
  import qcr_pkg::*;

  // 1.0 in Q3.28
  localparam logic signed [PART_W-1:0] UNIT_ONE =
    {{(PART_W-FRAC_W-1){1'b0}}, 1'b1, {FRAC_W{1'b0}}};

  logic in_beat;
  assign in_beat = in_valid_i && in_ready_i;

  `QCR_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i, "out beat dropped")
  `QCR_ASSERT(a_out_stable, out_valid_i && !out_ready_i |=> $stable(out_x_i) && $stable(out_w_i) && $stable(renorm_i), "stalled out beat changed")
  `QCR_ASSERT(a_busy_after_in, in_beat |=> !in_ready_i, "ready while composing")
  `QCR_ASSERT(a_new_out_from_busy, $rose(out_valid_i) |-> $past(!in_ready_i), "result without work")
  `QCR_ASSERT(a_renorm_unit, out_valid_i && renorm_i |-> out_x_i <= UNIT_ONE && out_x_i >= -UNIT_ONE && out_y_i <= UNIT_ONE && out_y_i >= -UNIT_ONE && out_z_i <= UNIT_ONE && out_z_i >= -UNIT_ONE && out_w_i <= UNIT_ONE && out_w_i >= -UNIT_ONE, "renormalized part above one")

endmodule

bind quaternion_compose_renormalize qcr_checker u_qcr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_ch_i.valid),
  .in_ready_i  (in_ch_i.ready),
  .out_valid_i (out_ch_o.valid),
  .out_ready_i (out_ch_o.ready),
  .out_x_i     (out_ch_o.out_x),
  .out_y_i     (out_ch_o.out_y),
  .out_z_i     (out_ch_o.out_z),
  .out_w_i     (out_ch_o.out_w),
  .renorm_i    (out_ch_o.renormalized)
);

>>> tb/quaternion_compose_renormalize_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for quaternion_compose_renormalize: random and corner quaternion pairs,
// renorm_period swept over its range. Needs qcr_pkg, qcr_in_if, qcr_out_if and the block.
module quaternion_compose_renormalize_tb;
  import qcr_pkg::*;

  // Q3.28 values used by the directed beats and the corner picker
  localparam logic signed [PART_W-1:0] Q_ONE      = 32'sh1000_0000;
  localparam logic signed [PART_W-1:0] Q_HALF     = 32'sh0800_0000;
  localparam logic signed [PART_W-1:0] Q_NEG_HALF = 32'shF800_0000;
  localparam logic signed [PART_W-1:0] Q_NEG_ONE  = 32'shF000_0000;
  localparam logic signed [PART_W-1:0] Q_COS45    = 32'sh0B50_4F33;
  localparam logic signed [PART_W-1:0] Q_MAX      = 32'sh7FFF_FFFF;
  localparam logic signed [PART_W-1:0] Q_MIN      = 32'sh8000_0000;
  localparam logic signed [PART_W-1:0] Q_LSB      = 32'sh0000_0001;
  localparam logic signed [PART_W-1:0] Q_NEG_LSB  = 32'shFFFF_FFFF;

  localparam logic signed [PART_W-1:0] CORNERS [7] =
    '{'0, Q_ONE, Q_NEG_ONE, Q_MAX, Q_MIN, Q_LSB, Q_NEG_LSB};

  localparam logic [CFG_ADDR_W-1:0] PERIOD_ADDR = {REG_RENORM_PERIOD, 2'b00};

  localparam int DIRECTED_N  = 12;
  localparam int PHASES      = 10;
  localparam int PHASE_BEATS = 158;
  localparam int PICK_ANY    = -1;   // plan entry: draw a random period
  // 127/0 are the extremes; 127 followed by 5 lowers the period under the live count
  localparam int PERIOD_PLAN [PHASES] = '{127, 5, 1, PICK_ANY, 127, 0, PICK_ANY, 63, 2, PICK_ANY};

  localparam int DRAIN_CYCLES = 200;          // longer than one renormalizing beat
  localparam longint RUN_LIMIT = 1_500_000;

  localparam logic signed [67:0] SAT_HI = 68'sd2147483647;
  localparam logic signed [67:0] SAT_LO = -68'sd2147483648;
  localparam logic signed [67:0] HALF_LSB_Q56 = 68'sd134217728;

  typedef struct packed {
    quat_t q;
    logic  renormalized;
  } composed_t;

  typedef enum {FLAVOR_WIDE, FLAVOR_NEAR_UNIT, FLAVOR_CORNER, FLAVOR_SPARSE} flavor_e;

  // Tracks period and count, predicts each composed beat and matches it on arrival.
  class quat_composer;
    logic [PERIOD_W-1:0] period;
    logic [PERIOD_W-1:0] count;
    composed_t           due_results [$];
    int unsigned         faults;
    int unsigned         results_seen;

    function new();
      period       = PERIOD_RESET;
      count        = '0;
      faults       = 0;
      results_seen = 0;
    endfunction

    function void flag(input string what);
      faults++;
      if (faults <= 10) $display("%s", what);
    endfunction

    function logic signed [67:0] mul(input logic signed [PART_W-1:0] a,
                                     input logic signed [PART_W-1:0] b);
      logic signed [67:0] wa;
      logic signed [67:0] wb;
      wa = a;
      wb = b;
      return wa * wb;
    endfunction

    // exact Q6.56 sum -> Q3.28, round half up, saturate
    function logic signed [PART_W-1:0] round_sat(input logic signed [67:0] acc);
      logic signed [67:0] r;
      r = (acc + HALF_LSB_Q56) >>> FRAC_W;
      if (r > SAT_HI) return Q_MAX;
      if (r < SAT_LO) return Q_MIN;
      return r[PART_W-1:0];
    endfunction

    function void take_pair(input quat_t f, input quat_t s);
      logic signed [PART_W-1:0] part [4];
      logic [PERIOD_W:0]        next;
      composed_t                exp;
      logic [65:0]              sumsq;
      logic [65:0]              rem;
      logic [65:0]              res;
      logic [65:0]              bitv;
      logic [32:0]              root;
      logic signed [32:0]       wide;
      logic [32:0]              magu;
      logic [63:0]              numer;
      logic [63:0]              quo;
      part[0] = round_sat(mul(f.x, s.w) + mul(s.x, f.w) + mul(s.y, f.z) - mul(s.z, f.y));
      part[1] = round_sat(mul(f.y, s.w) + mul(s.y, f.w) + mul(s.z, f.x) - mul(s.x, f.z));
      part[2] = round_sat(mul(f.z, s.w) + mul(s.z, f.w) + mul(s.x, f.y) - mul(s.y, f.x));
      part[3] = round_sat(mul(f.w, s.w) - mul(f.x, s.x) - mul(f.y, s.y) - mul(f.z, s.z));

      // count is compared one wider so a period of 127 fires on the 128th beat
      next = {1'b0, count} + 1'b1;
      exp.renormalized = next > {1'b0, period};
      count = exp.renormalized ? '0 : next[PERIOD_W-1:0];

      if (exp.renormalized) begin
        sumsq = '0;
        for (int i = 0; i < 4; i++) begin
          wide  = part[i];
          magu  = (wide < 0) ? -wide : wide;
          sumsq = sumsq + magu * magu;
        end
        // bitwise integer root; all parts at -8 gives exactly 2^64 -> 2^32
        rem  = sumsq;
        res  = '0;
        bitv = 66'd1 << 64;
        while (bitv > rem) bitv = bitv >> 2;
        while (bitv != 0) begin
          if (rem >= res + bitv) begin
            rem = rem - (res + bitv);
            res = (res >> 1) + bitv;
          end else begin
            res = res >> 1;
          end
          bitv = bitv >> 2;
        end
        root = res[32:0];
        // zero magnitude: parts stay zero, flag still set
        if (root != 0) begin
          for (int i = 0; i < 4; i++) begin
            wide    = part[i];
            magu    = (wide < 0) ? -wide : wide;
            numer   = magu;
            numer   = (numer << FRAC_W) + (root >> 1);
            quo     = numer / root;
            part[i] = (wide < 0) ? -quo[PART_W-1:0] : quo[PART_W-1:0];
          end
        end
      end

      exp.q.x = part[0];
      exp.q.y = part[1];
      exp.q.z = part[2];
      exp.q.w = part[3];
      due_results.push_back(exp);
    endfunction

    function void check_field(input string name, input logic [PART_W-1:0] e,
                              input logic [PART_W-1:0] a);
      if (a !== e) flag($sformatf("beat %0d %s: expected %h, got %h", results_seen, name, e, a));
    endfunction

    function void match_result(input composed_t got);
      composed_t exp;
      if (due_results.size() == 0) begin
        flag($sformatf("unexpected beat: x=%h y=%h z=%h w=%h renormalized=%b",
                       got.q.x, got.q.y, got.q.z, got.q.w, got.renormalized));
        return;
      end
      exp = due_results.pop_front();
      check_field("out_x", exp.q.x, got.q.x);
      check_field("out_y", exp.q.y, got.q.y);
      check_field("out_z", exp.q.z, got.q.z);
      check_field("out_w", exp.q.w, got.q.w);
      check_field("renormalized", exp.renormalized, got.renormalized);
      results_seen++;
    endfunction
  endclass

  // Directed pairs: zero magnitude, both extremes, all parts pinned at -8 (largest
  // magnitude), identity, rounding ties either sign, mixed extremes, 90-degree
  // rotations, pure vectors, tiny values, saturated negative scalar.
  localparam quat_t PROBE_FIRST [DIRECTED_N] = '{
    '{'0, '0, '0, '0},
    '{Q_MAX, Q_MAX, Q_MAX, Q_MAX},
    '{Q_MIN, Q_MIN, Q_MIN, Q_MIN},
    '{'0, '0, '0, Q_MIN},
    '{'0, '0, '0, Q_ONE},
    '{Q_LSB, '0, '0, '0},
    '{Q_NEG_LSB, '0, '0, '0},
    '{Q_MAX, Q_MIN, Q_MAX, Q_MIN},
    '{Q_COS45, '0, '0, Q_COS45},
    '{Q_ONE, '0, '0, '0},
    '{Q_NEG_LSB, Q_NEG_LSB, Q_NEG_LSB, Q_NEG_LSB},
    '{Q_MAX, '0, '0, '0}
  };
  localparam quat_t PROBE_SECOND [DIRECTED_N] = '{
    '{'0, '0, '0, '0},
    '{Q_MAX, Q_MAX, Q_MAX, Q_MAX},
    '{Q_MIN, Q_MIN, Q_MIN, Q_MIN},
    '{Q_ONE, Q_ONE, Q_ONE, Q_ONE},
    '{Q_HALF, Q_NEG_HALF, Q_HALF, Q_HALF},
    '{'0, '0, '0, Q_HALF},
    '{'0, '0, '0, Q_HALF},
    '{Q_MIN, Q_MAX, Q_MIN, Q_MAX},
    '{'0, Q_COS45, '0, Q_COS45},
    '{'0, Q_ONE, '0, '0},
    '{Q_LSB, Q_LSB, Q_LSB, Q_LSB},
    '{Q_MAX, '0, '0, '0}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  qcr_in_if  in_ch ();
  qcr_out_if out_ch ();

  quat_composer board = new();
  bit           steady_flow;     // set: neither side idles during this phase
  longint       cycle_count = 0;

  quaternion_compose_renormalize u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch_i  (in_ch),
    .out_ch_o (out_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // watchdog: a hung handshake or a lost beat ends here
  initial begin
    wait (cycle_count >= RUN_LIMIT);
    $display("quaternion_compose_renormalize: mismatch");
    $finish;
  end

  // Back-to-back in a steady phase; else mostly back-to-back, some short pauses, the odd long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (steady_flow) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Half the quaternions with every part within +-1.0, the rest full-range, corners or sparse.
  function automatic quat_t random_quat();
    logic signed [PART_W-1:0] v [4];
    flavor_e                  flavor;
    int unsigned              roll;
    quat_t                    q;
    roll   = $urandom_range(0, 9);
    flavor = (roll < 2) ? FLAVOR_WIDE :
             (roll < 7) ? FLAVOR_NEAR_UNIT :
             (roll < 9) ? FLAVOR_CORNER : FLAVOR_SPARSE;
    for (int i = 0; i < 4; i++) begin
      case (flavor)
        FLAVOR_WIDE:      v[i] = $urandom;
        FLAVOR_NEAR_UNIT: v[i] = $urandom_range(0, 2 * Q_ONE) - Q_ONE;
        FLAVOR_CORNER:    v[i] = CORNERS[$urandom_range(0, 6)];
        default:          v[i] = $urandom_range(0, 1) ? '0 : $urandom;
      endcase
    end
    q.x = v[0];
    q.y = v[1];
    q.z = v[2];
    q.w = v[3];
    return q;
  endfunction

  // One input beat; valid stays up across back-to-back beats.
  task automatic send_beat(input quat_t f, input quat_t s);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.first_x  <= f.x;
    in_ch.first_y  <= f.y;
    in_ch.first_z  <= f.z;
    in_ch.first_w  <= f.w;
    in_ch.second_x <= s.x;
    in_ch.second_y <= s.y;
    in_ch.second_z <= s.z;
    in_ch.second_w <= s.w;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    board.take_pair(f, s);
  endtask

  // Setup + access; data moves on the edge with penable and pready high.
  task automatic apb_transfer(input bit wr, input logic [CFG_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata    = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic verify_period();
    logic [APB_DATA_W-1:0] rd;
    apb_transfer(1'b0, PERIOD_ADDR, '0, rd);
    if (rd !== APB_DATA_W'(board.period))
      board.flag($sformatf("renorm_period read: expected %h, got %h",
                           APB_DATA_W'(board.period), rd));
  endtask

  // Only with the block idle: input low, every result drained.
  task automatic program_period(input logic [PERIOD_W-1:0] value);
    logic [APB_DATA_W-1:0] wdata;
    logic [APB_DATA_W-1:0] rd;
    in_ch.valid <= 1'b0;
    while (board.due_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    // junk in the unused upper bits half the time
    wdata = $urandom;
    if ($urandom_range(0, 1)) wdata = '0;
    wdata[PERIOD_W-1:0] = value;
    apb_transfer(1'b1, PERIOD_ADDR, wdata, rd);
    board.period = value;
    verify_period();
  endtask

  // Result side: check each accepted beat, then decide ready for the next edge.
  initial begin
    int unsigned hold;
    composed_t   got;
    hold = 0;
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) begin
        got.q.x          = out_ch.out_x;
        got.q.y          = out_ch.out_y;
        got.q.z          = out_ch.out_z;
        got.q.w          = out_ch.out_w;
        got.renormalized = out_ch.renormalized;
        board.match_result(got);
      end
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) hold = pick_gap();
      end
    end
  end

  // Stimulus: reset value check, directed pairs at the reset period and then at
  // period 0 (renormalize every beat, written under the live count), then
  // random phases walking the period plan.
  initial begin
    quat_t               f;
    quat_t               s;
    logic [PERIOD_W-1:0] period_val;
    steady_flow     = 1'b0;
    rst_ni         <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.first_x  <= '0;
    in_ch.first_y  <= '0;
    in_ch.first_z  <= '0;
    in_ch.first_w  <= '0;
    in_ch.second_x <= '0;
    in_ch.second_y <= '0;
    in_ch.second_z <= '0;
    in_ch.second_w <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    verify_period();
    for (int i = 0; i < DIRECTED_N; i++) send_beat(PROBE_FIRST[i], PROBE_SECOND[i]);
    program_period('0);
    for (int i = 0; i < DIRECTED_N; i++) send_beat(PROBE_FIRST[i], PROBE_SECOND[i]);

    for (int ph = 0; ph < PHASES; ph++) begin
      period_val = (PERIOD_PLAN[ph] == PICK_ANY) ? PERIOD_W'($urandom_range(0, 127))
                                                 : PERIOD_W'(PERIOD_PLAN[ph]);
      program_period(period_val);
      steady_flow = (ph % 3 == 2);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        f = random_quat();
        s = random_quat();
        send_beat(f, s);
      end
    end

    in_ch.valid <= 1'b0;
    while (board.due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.faults == 0 && board.due_results.size() == 0) begin
      $display("quaternion_compose_renormalize: match");
    end else begin
      $display("quaternion_compose_renormalize: mismatch");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hdl
hdl/qcr_pkg.sv
hdl/qcr_in_if.sv
hdl/qcr_out_if.sv
hdl/quaternion_compose_renormalize.sv
hdl/qcr_checker.sv
tb/quaternion_compose_renormalize_tb.sv
